### hw/rtl/gtt_pkg.sv
// Shared constants and types for the greedy IoU track table.
// No dependencies; used by every module of the block but the RAM.
package gtt_pkg;

  localparam int IN_W  = 104;
  localparam int OUT_W = 104;

  localparam logic CMD_DETECT = 1'b0;
  localparam logic CMD_EOF    = 1'b1;

  localparam logic [1:0] LIFE_NEW     = 2'd0;
  localparam logic [1:0] LIFE_TRACKED = 2'd1;
  localparam logic [1:0] LIFE_LOST    = 2'd2;

  localparam logic [2:0] CFG_MIN_IOU     = 3'd0;
  localparam logic [2:0] CFG_ALPHA       = 3'd1;
  localparam logic [2:0] CFG_MAX_FRAMES  = 3'd2;
  localparam logic [2:0] CFG_MAX_MS      = 3'd3;
  localparam logic [2:0] CFG_STILL_SPEED = 3'd4;

  localparam logic [8:0]  RST_MIN_IOU     = 9'd77;
  localparam logic [8:0]  RST_ALPHA       = 9'd179;
  localparam logic [7:0]  RST_MAX_FRAMES  = 8'd30;
  localparam logic [19:0] RST_MAX_MS      = 20'd4000;
  localparam logic [11:0] RST_STILL_SPEED = 12'd12;

  localparam logic [17:0] SPEED_SCALE = 18'd250000;

  typedef struct packed {
    logic done;
    logic found;
    logic free_found;
  } scan_stat_t;

endpackage

### hw/rtl/iou_greedy_track_table_unit.sv
// Greedy IoU track table: one detection or end-of-frame request at a time.
// A detection runs a scan that reads one track RAM entry per cycle, then a
// four-step match update, a track create written as the scan completes, or a
// table-full result. An end-of-frame request reads every slot and writes back each
// unmatched track. Synchronous reset clears the valid and match bits, sets the track
// counter to one, loads config defaults; the RAM has no reset or clearing pass.
module iou_greedy_track_table_unit #(
  parameter int MAX_TRACKS = 32,
  parameter int COORD_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // x_left, y_top, x_right, y_bottom, class_code, timestamp_ms
  input  logic [gtt_pkg::IN_W-1:0]   s_tdata,
  // command
  input  logic                       s_tuser,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // track_number, track_new, age_frames, dwell_ms, moving, life_state,
  // table_full, removed_count
  output logic [gtt_pkg::OUT_W-1:0]  m_tdata,
  // frame_done
  output logic                       m_tlast,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [2:0]                 cfg_index,
  input  logic [19:0]                cfg_data
);

  localparam int CB    = COORD_BITS;
  localparam int IDX_W = $clog2(MAX_TRACKS);
  localparam int RM_W  = $clog2(MAX_TRACKS + 1);
  localparam int D2_W  = 2 * CB + 3;
  localparam int CW    = (2 * CB + 21 > 48) ? 2 * CB + 21 : 48;

  typedef struct packed {
    logic [1:0]        life;
    logic [4*CB-1:0]   box;
    logic signed [8:0] cls;
    logic [31:0]       num;
    logic [39:0]       first;
    logic [39:0]       last;
    logic [15:0]       age;
    logic [7:0]        missed;
    logic              moving;
  } rec_t;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_SCAN   = 9'b000000010,
    ST_FETCH  = 9'b000000100,
    ST_MATH   = 9'b000001000,
    ST_WRITE  = 9'b000010000,
    ST_EOF_RD = 9'b000100000,
    ST_EOF_WR = 9'b001000000,
    ST_EOF_END = 9'b010000000,
    ST_EMIT   = 9'b100000000
  } state_t;

  state_t state;

  logic [8:0]  min_iou_q8, alpha_q8;
  logic [7:0]  max_missed_frames;
  logic [19:0] max_missed_ms;
  logic [11:0] still_speed_px_s;

  logic [MAX_TRACKS-1:0] valid, matched;
  logic [31:0]           next_num;
  logic [IDX_W:0]        i;
  logic [1:0]            k;
  logic [4*CB-1:0]       det, newbox;
  logic signed [8:0]     cls;
  logic [39:0]           ts;
  rec_t                  cur, rd_rec, wr_rec;
  logic signed [CB+1:0]  dx, dy;
  logic [39:0]           delta;
  logic [D2_W-1:0]       d2;
  logic [35:0]           sd;
  logic                  big, big2;
  logic [CW-1:0]         lhs, rhs;
  logic [RM_W-1:0]       removed;
  logic [gtt_pkg::OUT_W-1:0] res_data;
  logic                  res_last;

  logic                 scan_start;
  gtt_pkg::scan_stat_t  stat;
  logic [IDX_W-1:0]     scan_addr, best_idx, free_idx;
  logic [IDX_W-1:0]     raddr, waddr;
  logic                 we;
  logic [$bits(rec_t)-1:0] rdata;

  logic [8:0]        a;
  logic [CB-1:0]     edge_det, edge_old;
  logic [CB+8:0]     edge_sum;
  logic [39:0]       ls, first_upd, rm_ext;
  logic signed [40:0] dt, lost_dt;
  logic [7:0]        missed_upd;
  logic              drop, still;
  logic [15:0]       ext_xl, ext_yt, ext_xr, ext_yb;
  logic [8:0]        rem9;

  function automatic logic [gtt_pkg::OUT_W-1:0] pack_result(
    input logic [31:0] num, input logic is_new, input logic [15:0] age,
    input logic [39:0] dwell, input logic mov, input logic [1:0] life,
    input logic full, input logic [5:0] rem);
    pack_result = {5'b0, rem, full, life, mov, dwell, age, is_new, num};
  endfunction

  assign rd_rec = rec_t'(rdata);
  assign s_tready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign scan_start = s_tvalid && s_tready && (s_tuser == gtt_pkg::CMD_DETECT);

  assign ext_xl = {4'b0, s_tdata[11:0]};
  assign ext_yt = {4'b0, s_tdata[23:12]};
  assign ext_xr = {4'b0, s_tdata[35:24]};
  assign ext_yb = {4'b0, s_tdata[47:36]};

  gtt_iou_scan #(.MAX_TRACKS(MAX_TRACKS), .COORD_BITS(COORD_BITS)) u_scan (
    .clk(clk), .rst(rst), .start(scan_start),
    .det_box(det), .det_cls(cls), .min_iou(min_iou_q8),
    .elig(valid & ~matched), .free(~valid),
    .rd_addr(scan_addr), .slot_box(rd_rec.box), .slot_cls(rd_rec.cls),
    .stat(stat), .best_idx(best_idx), .free_idx(free_idx)
  );

  gtt_ram #(.WIDTH($bits(rec_t)), .DEPTH(MAX_TRACKS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wr_rec), .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    a = alpha_q8[8] ? 9'd256 : alpha_q8;
    edge_det = det[k*CB +: CB];
    edge_old = cur.box[k*CB +: CB];
    edge_sum = a * edge_det + (9'd256 - a) * edge_old;
    ls = (cur.last == '0) ? 40'd1 : cur.last;
    dt = $signed({1'b0, ts}) - $signed({1'b0, ls});
    first_upd = (cur.first == '0) ? ts : cur.first;
    still = big2 || (lhs <= rhs);
    missed_upd = (rd_rec.missed == 8'd255) ? 8'd255 : rd_rec.missed + 8'd1;
    rm_ext = {20'b0, max_missed_ms};
    lost_dt = $signed({1'b0, ts}) - $signed({1'b0, rd_rec.last});
    drop = (missed_upd > max_missed_frames) || (lost_dt > $signed({1'b0, rm_ext}));
    rem9 = 9'(removed);
  end

  always_comb begin
    raddr = scan_addr;
    we = 1'b0;
    waddr = best_idx;
    wr_rec = cur;
    case (state)
      ST_SCAN: begin
        raddr = stat.done ? best_idx : scan_addr;
        if (stat.done && !stat.found && stat.free_found) begin
          we = 1'b1;
          waddr = free_idx;
          wr_rec.life = gtt_pkg::LIFE_NEW;
          wr_rec.box = det;
          wr_rec.cls = cls;
          wr_rec.num = next_num;
          wr_rec.first = ts;
          wr_rec.last = ts;
          wr_rec.age = 16'd1;
          wr_rec.missed = 8'd0;
          wr_rec.moving = 1'b0;
        end
      end
      ST_WRITE: begin
        we = 1'b1;
        wr_rec.life = gtt_pkg::LIFE_TRACKED;
        wr_rec.box = newbox;
        wr_rec.cls = cls;
        wr_rec.first = first_upd;
        wr_rec.last = ts;
        wr_rec.age = (cur.age == 16'hFFFF) ? cur.age : cur.age + 16'd1;
        wr_rec.missed = 8'd0;
        wr_rec.moving = !still;
      end
      ST_EOF_RD: begin
        raddr = i[IDX_W-1:0];
      end
      ST_EOF_WR: begin
        we = 1'b1;
        waddr = i[IDX_W-1:0];
        wr_rec = rd_rec;
        wr_rec.missed = missed_upd;
        wr_rec.life = gtt_pkg::LIFE_LOST;
        wr_rec.moving = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_iou_q8 <= gtt_pkg::RST_MIN_IOU;
      alpha_q8 <= gtt_pkg::RST_ALPHA;
      max_missed_frames <= gtt_pkg::RST_MAX_FRAMES;
      max_missed_ms <= gtt_pkg::RST_MAX_MS;
      still_speed_px_s <= gtt_pkg::RST_STILL_SPEED;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gtt_pkg::CFG_MIN_IOU:     min_iou_q8 <= cfg_data[8:0];
        gtt_pkg::CFG_ALPHA:       alpha_q8 <= cfg_data[8:0];
        gtt_pkg::CFG_MAX_FRAMES:  max_missed_frames <= cfg_data[7:0];
        gtt_pkg::CFG_MAX_MS:      max_missed_ms <= cfg_data;
        gtt_pkg::CFG_STILL_SPEED: still_speed_px_s <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid <= '0;
      matched <= '0;
      next_num <= 32'd1;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            det <= {ext_yb[CB-1:0], ext_xr[CB-1:0], ext_yt[CB-1:0], ext_xl[CB-1:0]};
            cls <= $signed(s_tdata[56:48]);
            ts <= s_tdata[96:57];
            i <= '0;
            removed <= '0;
            state <= (s_tuser == gtt_pkg::CMD_EOF) ? ST_EOF_RD : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (stat.done) begin
            if (stat.found) begin
              state <= ST_FETCH;
            end else if (stat.free_found) begin
              valid[free_idx] <= 1'b1;
              matched[free_idx] <= 1'b1;
              next_num <= next_num + 32'd1;
              res_data <= pack_result(next_num, 1'b1, 16'd1, 40'd0, 1'b0,
                                      gtt_pkg::LIFE_NEW, 1'b0, 6'd0);
              res_last <= 1'b0;
              state <= ST_EMIT;
            end else begin
              res_data <= pack_result(32'd0, 1'b0, 16'd0, 40'd0, 1'b0,
                                      gtt_pkg::LIFE_NEW, 1'b1, 6'd0);
              res_last <= 1'b0;
              state <= ST_EMIT;
            end
          end
        end
        ST_FETCH: begin
          cur <= rd_rec;
          k <= 2'd0;
          state <= ST_MATH;
        end
        ST_MATH: begin
          newbox[k*CB +: CB] <= edge_sum[CB+7:8];
          k <= k + 2'd1;
          case (k)
            2'd0: begin
              dx <= $signed({2'b00, det[CB-1:0]}) + $signed({2'b00, det[3*CB-1:2*CB]})
                  - $signed({2'b00, cur.box[CB-1:0]}) - $signed({2'b00, cur.box[3*CB-1:2*CB]});
              dy <= $signed({2'b00, det[2*CB-1:CB]}) + $signed({2'b00, det[4*CB-1:3*CB]})
                  - $signed({2'b00, cur.box[2*CB-1:CB]}) - $signed({2'b00, cur.box[4*CB-1:3*CB]});
              delta <= (dt < 41'sd1) ? 40'd1 : dt[39:0];
            end
            2'd1: begin
              d2 <= D2_W'(dx * dx) + D2_W'(dy * dy);
              big <= (still_speed_px_s != '0) && (delta[39:24] != '0);
              sd <= still_speed_px_s * delta[23:0];
            end
            2'd2: begin
              big2 <= big || (sd[35:24] != '0);
              lhs <= CW'(d2 * gtt_pkg::SPEED_SCALE);
              rhs <= CW'(sd[23:0] * sd[23:0]);
            end
            default: begin
              state <= ST_WRITE;
            end
          endcase
        end
        ST_WRITE: begin
          matched[best_idx] <= 1'b1;
          res_data <= pack_result(cur.num, cur.life == gtt_pkg::LIFE_NEW,
                                  (cur.age == 16'hFFFF) ? cur.age : cur.age + 16'd1,
                                  (ts >= first_upd) ? ts - first_upd : 40'd0,
                                  !still, gtt_pkg::LIFE_TRACKED, 1'b0, 6'd0);
          res_last <= 1'b0;
          state <= ST_EMIT;
        end
        ST_EOF_RD: begin
          if (i == (IDX_W+1)'(MAX_TRACKS)) begin
            state <= ST_EOF_END;
          end else if (valid[i[IDX_W-1:0]] && !matched[i[IDX_W-1:0]]) begin
            state <= ST_EOF_WR;
          end else begin
            i <= i + 1'b1;
          end
        end
        ST_EOF_WR: begin
          if (drop) begin
            valid[i[IDX_W-1:0]] <= 1'b0;
            removed <= removed + 1'b1;
          end
          i <= i + 1'b1;
          state <= ST_EOF_RD;
        end
        ST_EOF_END: begin
          matched <= '0;
          res_data <= pack_result(32'd0, 1'b0, 16'd0, 40'd0, 1'b0, gtt_pkg::LIFE_NEW,
                                  1'b0, (rem9 > 9'd63) ? 6'd63 : rem9[5:0]);
          res_last <= 1'b1;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= res_data;
            m_tlast <= res_last;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/gtt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/gtt_iou_scan.sv
// Pipelined slot scan: one slot read per cycle, IoU test and best-match selection.
// Depends on gtt_pkg; reads slot boxes and classes from the track RAM in the top level.
module gtt_iou_scan #(
  parameter int MAX_TRACKS = 32,
  parameter int COORD_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [4*COORD_BITS-1:0]       det_box,
  input  logic signed [8:0]             det_cls,
  input  logic [8:0]                    min_iou,
  input  logic [MAX_TRACKS-1:0]         elig,
  input  logic [MAX_TRACKS-1:0]         free,
  output logic [$clog2(MAX_TRACKS)-1:0] rd_addr,
  input  logic [4*COORD_BITS-1:0]       slot_box,
  input  logic signed [8:0]             slot_cls,
  output gtt_pkg::scan_stat_t           stat,
  output logic [$clog2(MAX_TRACKS)-1:0] best_idx,
  output logic [$clog2(MAX_TRACKS)-1:0] free_idx
);

  localparam int CB    = COORD_BITS;
  localparam int IDX_W = $clog2(MAX_TRACKS);
  localparam int A_W   = 2 * CB;
  localparam int U_W   = 2 * CB + 1;

  logic             running;
  logic [IDX_W:0]   cnt;
  logic             v1, v2, v3, v4;
  logic             last1, last2, last3, last4;
  logic             ok1, ok2, ok3, ok4;
  logic [IDX_W-1:0] idx1, idx2, idx3, idx4;
  logic [CB-1:0]    iw2, ih2, bw2, bh2;
  logic [A_W-1:0]   it3, ab3, it4, det_area;
  logic [U_W-1:0]   un4;
  logic             found, free_found, done;
  logic [A_W-1:0]   bi;
  logic [U_W-1:0]   bu;

  logic [CB-1:0] d0, d1, d2, d3, b0, b1, b2, b3;
  logic [CB-1:0] l, t, r, d;
  logic          cls_ok, pass, better;
  logic [A_W+7:0]      thr_l;
  logic [A_W+9:0]      thr_r;
  logic [A_W+U_W-1:0]  cmp_new, cmp_old;

  assign d0 = det_box[CB-1:0];
  assign d1 = det_box[2*CB-1:CB];
  assign d2 = det_box[3*CB-1:2*CB];
  assign d3 = det_box[4*CB-1:3*CB];
  assign b0 = slot_box[CB-1:0];
  assign b1 = slot_box[2*CB-1:CB];
  assign b2 = slot_box[3*CB-1:2*CB];
  assign b3 = slot_box[4*CB-1:3*CB];

  always_comb begin
    l = (d0 > b0) ? d0 : b0;
    t = (d1 > b1) ? d1 : b1;
    r = (d2 < b2) ? d2 : b2;
    d = (d3 < b3) ? d3 : b3;
    cls_ok = !(!det_cls[8] && !slot_cls[8] && (det_cls != slot_cls));
    thr_l = {it4, 8'b0};
    thr_r = min_iou * un4;
    cmp_new = it4 * bu;
    cmp_old = bi * un4;
    pass = ok4 && (it4 != '0) && ({2'b0, thr_l} > thr_r);
    better = !found || (cmp_new > cmp_old);
  end

  assign rd_addr = cnt[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      found <= 1'b0;
      free_found <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= v4 && last4;
      if (start) begin
        running <= 1'b1;
        cnt <= '0;
        found <= 1'b0;
        free_found <= 1'b0;
        bi <= '0;
        bu <= U_W'(1);
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == (IDX_W+1)'(MAX_TRACKS - 1)) begin
          running <= 1'b0;
        end
        if (!free_found && free[cnt[IDX_W-1:0]]) begin
          free_found <= 1'b1;
          free_idx <= cnt[IDX_W-1:0];
        end
      end
      v1 <= running && !start;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      if (v4 && pass && better) begin
        found <= 1'b1;
        best_idx <= idx4;
        bi <= it4;
        bu <= un4;
      end
    end
  end

  always_ff @(posedge clk) begin
    det_area <= ((d2 > d0) ? d2 - d0 : '0) * ((d3 > d1) ? d3 - d1 : '0);
    idx1 <= cnt[IDX_W-1:0];
    last1 <= (cnt == (IDX_W+1)'(MAX_TRACKS - 1));
    ok1 <= elig[cnt[IDX_W-1:0]];
    idx2 <= idx1;
    last2 <= last1;
    ok2 <= ok1 && cls_ok;
    iw2 <= (r > l) ? r - l : '0;
    ih2 <= (d > t) ? d - t : '0;
    bw2 <= (b2 > b0) ? b2 - b0 : '0;
    bh2 <= (b3 > b1) ? b3 - b1 : '0;
    idx3 <= idx2;
    last3 <= last2;
    ok3 <= ok2;
    it3 <= iw2 * ih2;
    ab3 <= bw2 * bh2;
    idx4 <= idx3;
    last4 <= last3;
    ok4 <= ok3;
    it4 <= it3;
    un4 <= (it3 != '0) ? (U_W'(det_area) + U_W'(ab3) - U_W'(it3)) : '0;
  end

  assign stat.done = done;
  assign stat.found = found;
  assign stat.free_found = free_found;

endmodule

### hw/rtl/gtt_checker.sv
// Port-level checks for the greedy IoU track table, bound to the top level.
// Depends on gtt_pkg for the port widths.
module gtt_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [gtt_pkg::OUT_W-1:0] m_tdata,
  input logic                      m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Result changed while stalled.");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("Request taken while busy.");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Result valid after reset.");

  a_eof: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[92:0] == '0)
    else $error("End-of-frame result carries track fields.");

  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[92] |-> !m_tlast && m_tdata[91:0] == '0)
    else $error("Table-full result carries track fields.");

endmodule

bind iou_greedy_track_table_unit gtt_checker u_gtt_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);

### tb/iou_greedy_track_table_unit_tb.sv
// Self-checking testbench for the greedy IoU track table unit.
// Depends on gtt_pkg and iou_greedy_track_table_unit; predicts all untyped responses.
module iou_greedy_track_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 32;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int EXP_DEPTH = 4096;

  typedef struct packed {
    logic [31:0] number;
    logic        fresh;
    logic [15:0] age;
    logic [39:0] dwell;
    logic        moving;
    logic [1:0]  life;
    logic        full;
    logic [5:0]  removed;
    logic        done;
  } trk_res_t;

  typedef struct {
    logic        cmd;
    logic [11:0] xl, yt, xr, yb;
    logic [8:0]  cls;
    logic [39:0] ts;
    bit          typed;
    trk_res_t    want;
  } stim_row_t;

  logic clk, rst;
  logic s_tvalid, s_tready, s_tuser;
  logic [gtt_pkg::IN_W-1:0] s_tdata;
  logic m_tvalid, m_tready, m_tlast;
  logic [gtt_pkg::OUT_W-1:0] m_tdata;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [19:0] cfg_data;

  iou_greedy_track_table_unit i_dut (.*);

  // Predictor state
  bit          trk_valid[NSLOT], trk_matched[NSLOT], trk_moving[NSLOT];
  logic [1:0]  trk_life[NSLOT];
  int          trk_box[NSLOT][4];
  int          trk_cls[NSLOT];
  logic [31:0] trk_number[NSLOT];
  logic [39:0] trk_first[NSLOT], trk_last[NSLOT];
  int          trk_age[NSLOT], trk_missed[NSLOT];
  logic [31:0] next_number;
  int unsigned thr_iou, alpha, max_frames, max_ms, still_speed;

  trk_res_t exp_mem[EXP_DEPTH];
  int  exp_wr = 0;
  int  exp_rd = 0;
  int  err_count = 0;
  int  burst_left;
  bit  hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint sdiff(logic [39:0] x, logic [39:0] y);
    return longint'({24'b0, x}) - longint'({24'b0, y});
  endfunction

  function automatic longint span(int lo, int hi);
    return hi > lo ? longint'(hi - lo) : 0;
  endfunction

  function automatic void tracker_reset();
    for (int i = 0; i < NSLOT; i++) begin
      trk_valid[i] = 0;
      trk_matched[i] = 0;
    end
    next_number = 32'd1;
    thr_iou = gtt_pkg::RST_MIN_IOU;
    alpha = gtt_pkg::RST_ALPHA;
    max_frames = gtt_pkg::RST_MAX_FRAMES;
    max_ms = gtt_pkg::RST_MAX_MS;
    still_speed = gtt_pkg::RST_STILL_SPEED;
  endfunction

  function automatic trk_res_t track_step(stim_row_t r);
    trk_res_t res;
    int det[4];
    int cls, best, s, a, dx, dy, removed;
    longint bi, bu, it, un, aa, ab, dt;
    longint unsigned d2, sd, delta;
    logic [39:0] ls;
    bit still, was_new;
    res = '0;
    if (r.cmd == gtt_pkg::CMD_EOF) begin
      removed = 0;
      for (int i = 0; i < NSLOT; i++) begin
        if (trk_valid[i] && !trk_matched[i]) begin
          if (trk_missed[i] < 255) trk_missed[i]++;
          if (trk_missed[i] > max_frames || sdiff(r.ts, trk_last[i]) > longint'(max_ms)) begin
            trk_valid[i] = 0;
            removed++;
          end else begin
            trk_life[i] = gtt_pkg::LIFE_LOST;
            trk_moving[i] = 0;
          end
        end
        trk_matched[i] = 0;
      end
      res.removed = removed > 63 ? 6'd63 : 6'(removed);
      res.done = 1'b1;
      return res;
    end
    det[0] = r.xl; det[1] = r.yt; det[2] = r.xr; det[3] = r.yb;
    cls = int'($signed(r.cls));
    best = -1;
    bi = 0;
    bu = 1;
    for (int i = 0; i < NSLOT; i++) begin
      if (!trk_valid[i] || trk_matched[i]) continue;
      if (cls >= 0 && trk_cls[i] >= 0 && cls != trk_cls[i]) continue;
      it = span(det[0] > trk_box[i][0] ? det[0] : trk_box[i][0],
                det[2] < trk_box[i][2] ? det[2] : trk_box[i][2]) *
           span(det[1] > trk_box[i][1] ? det[1] : trk_box[i][1],
                det[3] < trk_box[i][3] ? det[3] : trk_box[i][3]);
      if (it == 0) continue;
      aa = span(det[0], det[2]) * span(det[1], det[3]);
      ab = span(trk_box[i][0], trk_box[i][2]) * span(trk_box[i][1], trk_box[i][3]);
      un = aa + ab - it;
      if (it * 256 <= longint'(thr_iou) * un) continue;
      if (best < 0 || it * bu > bi * un) begin
        best = i;
        bi = it;
        bu = un;
      end
    end
    if (best >= 0) begin
      s = best;
      a = alpha > 256 ? 256 : alpha;
      dx = det[0] + det[2] - trk_box[s][0] - trk_box[s][2];
      dy = det[1] + det[3] - trk_box[s][1] - trk_box[s][3];
      d2 = longint'(dx) * dx + longint'(dy) * dy;
      ls = trk_last[s] < 1 ? 40'd1 : trk_last[s];
      dt = sdiff(r.ts, ls);
      delta = dt < 1 ? 1 : dt;
      sd = still_speed * delta;
      still = sd >= (64'd1 << 24) ? 1'b1 : (d2 * 250000 <= sd * sd);
      was_new = trk_life[s] == gtt_pkg::LIFE_NEW;
      for (int k = 0; k < 4; k++)
        trk_box[s][k] = (a * det[k] + (256 - a) * trk_box[s][k]) >>> 8;
      trk_cls[s] = cls;
      trk_moving[s] = !still;
      if (trk_age[s] < 65535) trk_age[s]++;
      trk_missed[s] = 0;
      trk_last[s] = r.ts;
      if (trk_first[s] == 0) trk_first[s] = r.ts;
      trk_life[s] = gtt_pkg::LIFE_TRACKED;
      trk_matched[s] = 1;
      res.number = trk_number[s];
      res.fresh = was_new;
      res.age = 16'(trk_age[s]);
      res.dwell = trk_last[s] >= trk_first[s] ? trk_last[s] - trk_first[s] : 40'd0;
      res.moving = trk_moving[s];
      res.life = gtt_pkg::LIFE_TRACKED;
      return res;
    end
    s = -1;
    for (int i = NSLOT - 1; i >= 0; i--)
      if (!trk_valid[i]) s = i;
    if (s < 0) begin
      res.full = 1'b1;
      return res;
    end
    trk_valid[s] = 1;
    trk_matched[s] = 1;
    trk_life[s] = gtt_pkg::LIFE_NEW;
    for (int k = 0; k < 4; k++) trk_box[s][k] = det[k];
    trk_cls[s] = cls;
    trk_number[s] = next_number;
    next_number = next_number + 32'd1;
    trk_first[s] = r.ts;
    trk_last[s] = r.ts;
    trk_age[s] = 1;
    trk_missed[s] = 0;
    trk_moving[s] = 0;
    res.number = trk_number[s];
    res.fresh = 1'b1;
    res.age = 16'd1;
    res.life = gtt_pkg::LIFE_NEW;
    return res;
  endfunction

  task automatic offer(stim_row_t r);
    trk_res_t res;
    @(negedge clk);
    s_tuser = r.cmd;
    s_tdata = {7'b0, r.ts, r.cls, r.yb, r.xr, r.yt, r.xl};
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    res = track_step(r);
    exp_mem[exp_wr % EXP_DEPTH] = r.typed ? r.want : res;
    exp_wr++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk);
        s_tvalid = 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk);
      end
    end
  endtask

  task automatic write_reg(logic [2:0] idx, int unsigned val);
    @(negedge clk);
    cfg_index = idx;
    cfg_data = 20'(val);
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      gtt_pkg::CFG_MIN_IOU:     thr_iou = val & 32'h1FF;
      gtt_pkg::CFG_ALPHA:       alpha = val & 32'h1FF;
      gtt_pkg::CFG_MAX_FRAMES:  max_frames = val & 32'hFF;
      gtt_pkg::CFG_MAX_MS:      max_ms = val & 32'hFFFFF;
      gtt_pkg::CFG_STILL_SPEED: still_speed = val & 32'hFFF;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic int clamp12(int v);
    return v < 0 ? 0 : (v > 4095 ? 4095 : v);
  endfunction

  function automatic stim_row_t random_detection(logic [39:0] ts);
    stim_row_t r;
    int pick[NSLOT];
    int n_pick, s, x, y, mode;
    r = '{default: '0};
    r.cmd = gtt_pkg::CMD_DETECT;
    r.ts = ts;
    r.cls = 9'($urandom_range(0, 7));
    n_pick = 0;
    for (int i = 0; i < NSLOT; i++)
      if (trk_valid[i]) begin
        pick[n_pick] = i;
        n_pick++;
      end
    mode = $urandom_range(0, 99);
    if (mode < 70 && n_pick != 0) begin
      s = pick[$urandom_range(0, n_pick - 1)];
      r.xl = 12'(clamp12(trk_box[s][0] + $urandom_range(0, 24) - 12));
      r.yt = 12'(clamp12(trk_box[s][1] + $urandom_range(0, 24) - 12));
      r.xr = 12'(clamp12(trk_box[s][2] + $urandom_range(0, 24) - 12));
      r.yb = 12'(clamp12(trk_box[s][3] + $urandom_range(0, 24) - 12));
      case ($urandom_range(0, 5))
        0: r.cls = 9'h1FF;
        1: r.cls = 9'($urandom_range(0, 7));
        default: r.cls = 9'(trk_cls[s]);
      endcase
    end else if (mode < 92) begin
      x = $urandom_range(0, 3900);
      y = $urandom_range(0, 3900);
      r.xl = 12'(x);
      r.yt = 12'(y);
      r.xr = 12'(clamp12(x + $urandom_range(1, 190)));
      r.yb = 12'(clamp12(y + $urandom_range(1, 190)));
    end else begin
      r.xl = 12'($urandom);
      r.yt = 12'($urandom);
      r.xr = 12'($urandom);
      r.yb = 12'($urandom);
      r.cls = 9'($urandom);
    end
    return r;
  endfunction

  // Receiver: the stall pattern changes at random; a hold request blocks it once for long.
  initial begin
    int pattern;
    bit held;
    m_tready = 1'b0;
    pattern = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if ($urandom_range(0, 63) == 0) pattern = $urandom_range(0, 2);
        case (pattern)
          0: m_tready = 1'b1;
          1: m_tready = $urandom_range(0, 1);
          default: m_tready = $urandom_range(0, 3) == 0;
        endcase
      end
    end
  end

  // Response checker and watchdog.
  initial begin
    trk_res_t got, want;
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got = {m_tdata[31:0], m_tdata[32], m_tdata[48:33], m_tdata[88:49], m_tdata[89],
               m_tdata[91:90], m_tdata[92], m_tdata[98:93], m_tlast};
        if (exp_wr == exp_rd) begin
          $error("unexpected response %h", got);
          err_count++;
        end else begin
          want = exp_mem[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (got.number != want.number) begin
            $error("track_number exp %0d got %0d", want.number, got.number); err_count++;
          end
          if (got.fresh != want.fresh) begin
            $error("track_new exp %0d got %0d", want.fresh, got.fresh); err_count++;
          end
          if (got.age != want.age) begin
            $error("age_frames exp %0d got %0d", want.age, got.age); err_count++;
          end
          if (got.dwell != want.dwell) begin
            $error("dwell_ms exp %0d got %0d", want.dwell, got.dwell); err_count++;
          end
          if (got.moving != want.moving) begin
            $error("moving exp %0d got %0d", want.moving, got.moving); err_count++;
          end
          if (got.life != want.life) begin
            $error("life_state exp %0d got %0d", want.life, got.life); err_count++;
          end
          if (got.full != want.full) begin
            $error("table_full exp %0d got %0d", want.full, got.full); err_count++;
          end
          if (got.removed != want.removed) begin
            $error("removed_count exp %0d got %0d", want.removed, got.removed); err_count++;
          end
          if (got.done != want.done) begin
            $error("frame_done exp %0d got %0d", want.done, got.done); err_count++;
          end
        end
      end
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  localparam trk_res_t NEW_1 = {32'd1, 1'b1, 16'd1, 40'd0, 1'b0, gtt_pkg::LIFE_NEW,
                                1'b0, 6'd0, 1'b0};
  localparam trk_res_t NEW_2 = {32'd2, 1'b1, 16'd1, 40'd0, 1'b0, gtt_pkg::LIFE_NEW,
                                1'b0, 6'd0, 1'b0};
  localparam trk_res_t NEW_3 = {32'd3, 1'b1, 16'd1, 40'd0, 1'b0, gtt_pkg::LIFE_NEW,
                                1'b0, 6'd0, 1'b0};
  localparam trk_res_t NEW_4 = {32'd4, 1'b1, 16'd1, 40'd0, 1'b0, gtt_pkg::LIFE_NEW,
                                1'b0, 6'd0, 1'b0};
  localparam trk_res_t EOF_0 = {32'd0, 1'b0, 16'd0, 40'd0, 1'b0, 2'd0, 1'b0, 6'd0, 1'b1};

  stim_row_t directed[14];
  int unsigned reg_set[6][5];

  initial begin
    logic [39:0] ts;
    int n_det;
    burst_left = 4;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = gtt_pkg::CFG_MIN_IOU;
    cfg_data = '0;
    tracker_reset();

    directed = '{
      '{gtt_pkg::CMD_DETECT, 12'd10, 12'd10, 12'd100, 12'd100, 9'd3, 40'd0, 1'b1, NEW_1},
      '{gtt_pkg::CMD_DETECT, 12'd10, 12'd10, 12'd100, 12'd100, 9'd5, 40'd0, 1'b1, NEW_2},
      '{gtt_pkg::CMD_DETECT, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 9'd255, 40'd0, 1'b1,
        NEW_3},
      '{gtt_pkg::CMD_DETECT, 12'd0, 12'd0, 12'd4095, 12'd4095, 9'h1FF, 40'hFF_FFFF_FFFF,
        1'b1, NEW_4},
      '{gtt_pkg::CMD_EOF, 12'd0, 12'd0, 12'd0, 12'd0, 9'd0, 40'd0, 1'b1, EOF_0},
      '{gtt_pkg::CMD_DETECT, 12'd12, 12'd12, 12'd102, 12'd102, 9'h1FF, 40'd100, 1'b0, '0},
      '{gtt_pkg::CMD_DETECT, 12'd10, 12'd10, 12'd100, 12'd100, 9'd255, 40'd100, 1'b0, '0},
      '{gtt_pkg::CMD_DETECT, 12'd300, 12'd300, 12'd200, 12'd200, 9'h100, 40'd100, 1'b0, '0},
      '{gtt_pkg::CMD_EOF, 12'd0, 12'd0, 12'd0, 12'd0, 9'd0, 40'd100, 1'b0, '0},
      '{gtt_pkg::CMD_DETECT, 12'd40, 12'd40, 12'd130, 12'd130, 9'd5, 40'd150, 1'b0, '0},
      '{gtt_pkg::CMD_DETECT, 12'd11, 12'd11, 12'd101, 12'd101, 9'd7, 40'd150, 1'b0, '0},
      '{gtt_pkg::CMD_EOF, 12'd0, 12'd0, 12'd0, 12'd0, 9'd0, 40'd150, 1'b0, '0},
      '{gtt_pkg::CMD_EOF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 9'h1FF, 40'd5000, 1'b0, '0},
      '{gtt_pkg::CMD_DETECT, 12'd500, 12'd500, 12'd520, 12'd520, 9'd1, 40'd5000, 1'b0, '0}
    };
    reg_set = '{
      '{0, 0, 0, 0, 0},
      '{256, 256, 255, 1048575, 4095},
      '{511, 511, 3, 500, 40},
      '{40, 128, 10, 2000, 0},
      '{77, 179, 30, 4000, 12},
      '{120, 300, 255, 100000, 4095}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) offer(directed[i]);
    @(negedge clk);
    s_tvalid = 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      for (int k = 0; k < 5; k++) write_reg(3'(k), reg_set[ph][k]);
      if (ph == 3) hold_req = 1'b1;
      ts = ($urandom_range(0, 3) == 0) ? {8'($urandom), 32'($urandom)} : 40'd1000;
      n_det = 0;
      while (n_det < 200) begin
        repeat ($urandom_range(0, 12)) begin
          offer(random_detection(ts));
          n_det++;
        end
        offer('{gtt_pkg::CMD_EOF, 12'($urandom), 12'($urandom), 12'($urandom),
                12'($urandom), 9'($urandom), ts, 1'b0, '0});
        n_det++;
        case ($urandom_range(0, 19))
          0, 1:    ts = ts + 40'($urandom_range(3000, 9000));
          2:       ts = ts;
          3:       ts = ($urandom_range(0, 1) == 0) ? 40'd0 : {8'($urandom), 32'($urandom)};
          default: ts = ts + 40'($urandom_range(1, 600));
        endcase
      end
      @(negedge clk);
      s_tvalid = 1'b0;
    end

    while (exp_wr != exp_rd) @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
